// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/rmth_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmth_pkg
// shared types and constants of the running median core
// ---------------------------------------------------------------------------
package rmth_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned MedianW = 33;
  localparam int unsigned OutCntW = 11;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [MedianW-1:0] median_t;

  // command broadcast to every cell of one chain
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    sample_t  value;
  } chain_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_BALANCE,
    ST_RESULT
  } core_state_e;

endpackage

// File: rtl/core/rmth_sample_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmth_sample_if
// input channel: one signed sample per item
// ---------------------------------------------------------------------------
interface rmth_sample_if;
  logic              valid;
  logic              ready;
  rmth_pkg::sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

// File: rtl/core/rmth_result_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmth_result_if
// result channel: doubled median, accept flag and stored count
// ---------------------------------------------------------------------------
interface rmth_result_if;
  logic                             valid;
  logic                             ready;
  rmth_pkg::median_t                median_times_two;
  logic                             accepted;
  logic [rmth_pkg::OutCntW-1:0]     stored_count;

  modport source (output valid, output median_times_two, output accepted,
                  output stored_count, input ready);
  modport sink (input valid, input median_times_two, input accepted,
                input stored_count, output ready);
endinterface

// File: rtl/core/rmth_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmth_cell
// one slot of a sorted chain; inserts by shifting away from the top, pops
// by shifting toward it
// ---------------------------------------------------------------------------
module rmth_cell #(
  parameter int unsigned Idx   = 0,
  parameter int unsigned CntW  = 10,
  parameter bit          IsMax = 1'b1
) (
  input  logic                 clk_i,
  input  rmth_pkg::chain_cmd_t cmd_i,
  input  logic [CntW-1:0]      count_i,
  input  rmth_pkg::sample_t    prev_val_i,
  input  logic                 prev_keep_i,
  input  rmth_pkg::sample_t    next_val_i,
  output rmth_pkg::sample_t    val_o,
  output logic                 keep_o
);

  rmth_pkg::sample_t val_q, val_d;
  logic              occ;
  logic              ranks;

  assign occ   = count_i > CntW'(Idx);
  // stored value stays ahead of the new one
  assign ranks = IsMax ? (val_q >= cmd_i.value) : (val_q <= cmd_i.value);
  assign keep_o = occ && ranks;
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      rmth_pkg::OP_INSERT: begin
        if (keep_o) begin
          val_d = val_q;
        end else if (prev_keep_i) begin
          val_d = cmd_i.value;
        end else begin
          val_d = prev_val_i;
        end
      end
      rmth_pkg::OP_POP: val_d = next_val_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: rtl/core/rmth_chain.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rmth_chain
// row of cells kept sorted with the top entry in cell zero
// ---------------------------------------------------------------------------
module rmth_chain #(
  parameter int unsigned Depth = 513,
  parameter int unsigned CntW  = 10,
  parameter bit          IsMax = 1'b1
) (
  input  logic                 clk_i,
  input  rmth_pkg::chain_cmd_t cmd_i,
  input  logic [CntW-1:0]      count_i,
  output rmth_pkg::sample_t    top_o
);

  rmth_pkg::sample_t vals [Depth];
  logic              keeps [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    rmth_pkg::sample_t prev_val;
    rmth_pkg::sample_t next_val;
    logic              prev_keep;

    if (i == 0) begin : g_head
      assign prev_val  = cmd_i.value;
      assign prev_keep = 1'b1;
    end else begin : g_body
      assign prev_val  = vals[i-1];
      assign prev_keep = keeps[i-1];
    end

    if (i == Depth - 1) begin : g_tail
      assign next_val = vals[i];
    end else begin : g_inner
      assign next_val = vals[i+1];
    end

    rmth_cell #(
      .Idx   (i),
      .CntW  (CntW),
      .IsMax (IsMax)
    ) u_cell (
      .clk_i       (clk_i),
      .cmd_i       (cmd_i),
      .count_i     (count_i),
      .prev_val_i  (prev_val),
      .prev_keep_i (prev_keep),
      .next_val_i  (next_val),
      .val_o       (vals[i]),
      .keep_o      (keeps[i])
    );
  end

  assign top_o = vals[0];

endmodule

// File: rtl/core/running_median_two_heap_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// running_median_two_heap_core
// running median of signed samples, lower half and upper half each held in
// a sorted chain of cells, every item reports twice the median
//
//   channel  dir  payload                                    accepted when
//   in_i     in   sample                                     valid && ready
//   out_o    out  median_times_two, accepted, stored_count   valid && ready
//
// steps per item: accept, insert step, rebalance step, result load, with
//   the two chain steps issued by the sequencer one after the other
// a full store skips both chain steps and goes from accept to result load
// reset clears both counts, cell contents need none
// a result waits in the output register while the next item is taken in;
//   that item then holds at its result step until the register frees up
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module running_median_two_heap_core #(
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  rmth_sample_if.sink   in_i,
  rmth_result_if.source out_o
);

  // each chain gets one spare cell: the lower side can run one over its
  // share between the insert step and the rebalance step
  localparam int unsigned Depth = MAX_SAMPLES / 2 + 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam int unsigned TotW  = $clog2(MAX_SAMPLES + 1);
  localparam logic [TotW-1:0] MaxTotal = TotW'(MAX_SAMPLES);

  rmth_pkg::core_state_e state_q, state_d;

  // per-side entry counts
  logic [CntW-1:0] nl_q, nl_d;
  logic [CntW-1:0] nu_q, nu_d;
  logic [TotW-1:0] total;

  rmth_pkg::sample_t sample_q;
  logic              acc_q, acc_d;

  rmth_pkg::chain_cmd_t lcmd, ucmd;
  rmth_pkg::sample_t    l_top, u_top;

  logic in_fire;
  logic has_room;
  logic to_lower;
  logic lower_over;
  logic upper_over;
  logic load_out;

  // output register
  logic                         out_valid_q;
  rmth_pkg::median_t            med_q;
  logic                         acc_out_q;
  logic [rmth_pkg::OutCntW-1:0] cnt_q;
  rmth_pkg::median_t            med_d;

  assign total    = TotW'(nl_q) + TotW'(nu_q);
  assign in_fire  = in_i.valid && in_i.ready;
  assign has_room = total < MaxTotal;

  // new sample goes low when the lower side is empty or it sits below the max
  assign to_lower   = (nl_q == '0) || (sample_q < l_top);
  assign lower_over = (CntW+1)'(nl_q) > ((CntW+1)'(nu_q) + (CntW+1)'(1));
  assign upper_over = nu_q > nl_q;

  // lower side: descending, max in cell zero
  rmth_chain #(
    .Depth (Depth),
    .CntW  (CntW),
    .IsMax (1'b1)
  ) u_lower (
    .clk_i   (clk_i),
    .cmd_i   (lcmd),
    .count_i (nl_q),
    .top_o   (l_top)
  );

  // upper side: ascending, min in cell zero
  rmth_chain #(
    .Depth (Depth),
    .CntW  (CntW),
    .IsMax (1'b0)
  ) u_upper (
    .clk_i   (clk_i),
    .cmd_i   (ucmd),
    .count_i (nu_q),
    .top_o   (u_top)
  );

  // doubled median: even count sums both tops, odd count doubles the lower
  always_comb begin
    med_d = '0;
    if (nl_q != '0) begin
      if (!total[0] && (nu_q != '0)) begin
        med_d = rmth_pkg::median_t'(l_top) + rmth_pkg::median_t'(u_top);
      end else begin
        med_d = {l_top, 1'b0};
      end
    end
  end

  // sequencer: next state and chain commands
  always_comb begin
    state_d     = state_q;
    nl_d        = nl_q;
    nu_d        = nu_q;
    acc_d       = acc_q;
    load_out    = 1'b0;
    in_i.ready  = 1'b0;
    lcmd.op     = rmth_pkg::OP_HOLD;
    lcmd.value  = sample_q;
    ucmd.op     = rmth_pkg::OP_HOLD;
    ucmd.value  = sample_q;
    case (state_q)
      rmth_pkg::ST_IDLE: begin
        // ready is high here, so valid alone marks an accepted item
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          acc_d   = has_room;
          state_d = has_room ? rmth_pkg::ST_INSERT : rmth_pkg::ST_RESULT;
        end
      end
      rmth_pkg::ST_INSERT: begin
        if (to_lower) begin
          lcmd.op = rmth_pkg::OP_INSERT;
          nl_d    = nl_q + CntW'(1);
        end else begin
          ucmd.op = rmth_pkg::OP_INSERT;
          nu_d    = nu_q + CntW'(1);
        end
        state_d = rmth_pkg::ST_BALANCE;
      end
      rmth_pkg::ST_BALANCE: begin
        // move one top across so lower holds as many as upper or one more
        if (lower_over) begin
          lcmd.op    = rmth_pkg::OP_POP;
          ucmd.op    = rmth_pkg::OP_INSERT;
          ucmd.value = l_top;
          nl_d       = nl_q - CntW'(1);
          nu_d       = nu_q + CntW'(1);
        end else if (upper_over) begin
          ucmd.op    = rmth_pkg::OP_POP;
          lcmd.op    = rmth_pkg::OP_INSERT;
          lcmd.value = u_top;
          nu_d       = nu_q - CntW'(1);
          nl_d       = nl_q + CntW'(1);
        end
        state_d = rmth_pkg::ST_RESULT;
      end
      rmth_pkg::ST_RESULT: begin
        if (!out_valid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = rmth_pkg::ST_IDLE;
        end
      end
      default: state_d = rmth_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmth_pkg::ST_IDLE;
      nl_q        <= '0;
      nu_q        <= '0;
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nl_q    <= nl_d;
      nu_q    <= nu_d;
      acc_q   <= acc_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sample_q <= in_i.sample;
    end
    if (load_out) begin
      med_q     <= med_d;
      acc_out_q <= acc_q;
      cnt_q     <= rmth_pkg::OutCntW'(total);
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.median_times_two = med_q;
  assign out_o.accepted         = acc_out_q;
  assign out_o.stored_count     = cnt_q;

  // halves stay balanced between items
  `ASSERT_IMPLIES(a_balanced, clk_i, rst_ni, state_q == rmth_pkg::ST_IDLE,
    (nl_q == nu_q) || ((CntW+1)'(nl_q) == (CntW+1)'(nu_q) + (CntW+1)'(1)))
  // the store never holds more than its limit
  `ASSERT_IMPLIES(a_total_limit, clk_i, rst_ni, 1'b1, total <= MaxTotal)
  // a dropped sample is reported only when the store is full
  `ASSERT_IMPLIES(a_drop_full, clk_i, rst_ni, load_out && !acc_q, total == MaxTotal)
  // an accepted item moves to the insert step, or straight to the result when full
  `ASSERT_NEXT(a_accept_step, clk_i, rst_ni, in_fire,
    (state_q == rmth_pkg::ST_INSERT) || (state_q == rmth_pkg::ST_RESULT))

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for running_median_two_heap_core: streams signed
// samples, predicts the doubled median, accept flag and stored count of
// every item, and compares each result item in order as it leaves the core
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned MaxSamples  = 1024;
  localparam int unsigned RandomItems = 1730;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned HoldCycles  = 600;
  localparam int unsigned IdlePct     = 35;

  typedef struct {
    rmth_pkg::median_t            median;
    logic                         accepted;
    logic [rmth_pkg::OutCntW-1:0] count;
  } median_result_t;

  // keeps the smaller half and the larger half of the held samples, both
  // sorted ascending: the lower top is the last entry, the upper top the first
  class median_scoreboard;
    rmth_pkg::sample_t lower_half[$];
    rmth_pkg::sample_t upper_half[$];
    median_result_t    pending_medians[$];
    int unsigned       mismatch_count;
    int unsigned       result_index;

    task report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", result_index, msg);
      mismatch_count++;
    endtask

    function void insert_sorted(ref rmth_pkg::sample_t q[$],
                                input rmth_pkg::sample_t v);
      int idx;
      idx = 0;
      while (idx < q.size() && q[idx] <= v) idx++;
      q.insert(idx, v);
    endfunction

    function int unsigned outstanding();
      return pending_medians.size();
    endfunction

    function void note_sample(input rmth_pkg::sample_t s);
      median_result_t    r;
      int unsigned       held;
      rmth_pkg::sample_t lo_top;
      rmth_pkg::sample_t hi_top;
      held       = lower_half.size() + upper_half.size();
      r.accepted = (held < MaxSamples);
      if (r.accepted) begin
        if (lower_half.size() == 0 || s < lower_half[$]) begin
          insert_sorted(lower_half, s);
          // lower grew two past the upper: its top moves across
          if (lower_half.size() > upper_half.size() + 1)
            upper_half.push_front(lower_half.pop_back());
        end else begin
          insert_sorted(upper_half, s);
          if (upper_half.size() > lower_half.size())
            lower_half.push_back(upper_half.pop_front());
        end
        held = lower_half.size() + upper_half.size();
      end
      lo_top   = lower_half[$];
      r.median = '0;
      if (held[0] == 1'b0 && upper_half.size() > 0) begin
        hi_top   = upper_half[0];
        r.median = rmth_pkg::median_t'({lo_top[rmth_pkg::SampleW-1], lo_top})
                 + rmth_pkg::median_t'({hi_top[rmth_pkg::SampleW-1], hi_top});
      end else begin
        r.median = rmth_pkg::median_t'({lo_top, 1'b0});
      end
      r.count = held[rmth_pkg::OutCntW-1:0];
      pending_medians.push_back(r);
    endfunction

    task check_result(input rmth_pkg::median_t m, input logic acc,
                      input logic [rmth_pkg::OutCntW-1:0] cnt);
      median_result_t want;
      if (pending_medians.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding (median2 %0d)", m));
      end else begin
        want = pending_medians.pop_front();
        if (m !== want.median)
          report_mismatch($sformatf("median_times_two got %0d expected %0d", m, want.median));
        if (acc !== want.accepted)
          report_mismatch($sformatf("accepted got %b expected %b", acc, want.accepted));
        if (cnt !== want.count)
          report_mismatch($sformatf("stored_count got %0d expected %0d", cnt, want.count));
      end
      result_index++;
    endtask
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  rmth_sample_if in_if ();
  rmth_result_if out_if ();

  median_scoreboard median_sb = new();

  // both sides run without gaps while set
  bit          steady_phase = 1'b0;
  // asks the result side for one long hold-off
  bit          hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned cycle_count  = 0;

  running_median_two_heap_core #(
    .MAX_SAMPLES(MaxSamples)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // offers one sample and returns at the edge that accepts it; valid is
  // left high so a following call can keep it up without a gap
  task automatic send_sample(input rmth_pkg::sample_t s);
    while (!steady_phase && hold_left == 0 && $urandom_range(99) < IdlePct) begin
      in_if.valid  <= 1'b0;
      in_if.sample <= rmth_pkg::sample_t'($urandom);
      @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    median_sb.note_sample(s);
  endtask

  function automatic rmth_pkg::sample_t random_sample(input rmth_pkg::sample_t recent);
    int v;
    case ($urandom_range(9))
      0, 1, 2: return rmth_pkg::sample_t'($urandom);
      3, 4: begin
        // narrow band around zero, many repeats
        v = int'($urandom_range(40)) - 20;
        return rmth_pkg::sample_t'(v);
      end
      5: return rmth_pkg::sample_t'(32'h7fff_ffff - $urandom_range(15));
      6: return rmth_pkg::sample_t'(32'h8000_0000 + $urandom_range(15));
      7: return recent;
      default: begin
        v = int'($urandom_range(2000)) - 1000;
        return rmth_pkg::sample_t'(v * 1000 + int'($urandom_range(999)));
      end
    endcase
  endfunction

  // result side: checks every accepted result item and plays the stalls
  initial begin : result_sink
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1)
        median_sb.check_result(out_if.median_times_two, out_if.accepted,
                               out_if.stored_count);
      if (hold_request && hold_left == 0) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (steady_phase) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= IdlePct);
      end
    end
  end

  initial begin : sample_source
    rmth_pkg::sample_t directed_samples[$];
    rmth_pkg::sample_t recent;

    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both tops at the minimum, then at the maximum, then mixed extremes
    directed_samples = '{
      rmth_pkg::sample_t'(32'h8000_0000), rmth_pkg::sample_t'(32'h8000_0000),
      rmth_pkg::sample_t'(32'h7fff_ffff), rmth_pkg::sample_t'(32'h7fff_ffff),
      rmth_pkg::sample_t'(32'h7fff_ffff), rmth_pkg::sample_t'(32'h7fff_ffff),
      rmth_pkg::sample_t'(32'h0000_0000), rmth_pkg::sample_t'(32'hffff_ffff),
      rmth_pkg::sample_t'(32'h0000_0001), rmth_pkg::sample_t'(32'h5555_5555),
      rmth_pkg::sample_t'(32'haaaa_aaaa), rmth_pkg::sample_t'(32'h0000_0000),
      rmth_pkg::sample_t'(32'h0000_0000), rmth_pkg::sample_t'(32'h8000_0001),
      rmth_pkg::sample_t'(32'h7fff_fffe), rmth_pkg::sample_t'(32'hffff_fffe),
      rmth_pkg::sample_t'(32'h0000_0002), rmth_pkg::sample_t'(32'h4000_0000)
    };
    foreach (directed_samples[k]) send_sample(directed_samples[k]);

    recent = '0;
    for (int n = 0; n < RandomItems; n++) begin
      // one long hold-off on the result side while samples keep coming
      if (n == 250) hold_request = 1'b1;
      steady_phase = (n >= 700 && n < 1000);
      recent = random_sample(recent);
      send_sample(recent);
    end
    in_if.valid  <= 1'b0;
    steady_phase = 1'b0;

    while (median_sb.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (median_sb.mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
